// ===== design/rsi_pkg.sv =====
// -----------------------------------------------------------------------------
// Ray-sphere intersection package
// Shared constants, configuration register indexes and the ray record type.
// -----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOWS  = 3'd4;

  // Register reset values and limits.
  localparam logic [30:0] RADIUS_RESET = 31'd65536;
  localparam logic [30:0] T_MAX        = 31'h7FFF_FFFF;
  localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN      = 32'h8000_0000;

  // Ray as it travels down the pipeline: query kind, origin, direction and
  // the saturated offset from the sphere center.
  typedef struct packed {
    logic            kind;
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [2:0][31:0] off;
  } rsi_ray_t;

endpackage

`default_nettype wire

// ===== design/ray_sphere_intersect_unit.sv =====
// Throughput: one ray per cycle while no held result stalls the pipeline; the rate is set
// by the fully pipelined square root (64 stages), root divider (65 + FRAC_BITS
// stages) and normal divider (64 stages), each resolving one result bit per stage.
// Reset: synchronous; clears all stage valid bits and loads the sphere
// registers with center 0, radius 1.0 and shadows enabled.
// -----------------------------------------------------------------------------
// Ray-sphere intersection unit
// Solves the half-b quadratic for one ray against the configured sphere and
// returns hit flag, distance, unit normal and hit point (the last two zero for shadow rays).
// -----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_unit
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Ray input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 kind,
  input  wire logic [31:0]          origin_x,
  input  wire logic [31:0]          origin_y,
  input  wire logic [31:0]          origin_z,
  input  wire logic [31:0]          dir_x,
  input  wire logic [31:0]          dir_y,
  input  wire logic [31:0]          dir_z,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      hit_found,
  output logic [30:0]               distance,
  output logic [31:0]               normal_x,
  output logic [31:0]               normal_y,
  output logic [31:0]               normal_z,
  output logic [31:0]               point_x,
  output logic [31:0]               point_y,
  output logic [31:0]               point_z,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int NUM_W = 65 + FRAC_BITS;
  localparam int SQ_N  = 64;
  localparam int ND_N  = 64;
  localparam logic [30:0] EPS_Q = 31'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  // Square root stage record.
  typedef struct packed {
    logic             miss;
    rsi_ray_t         ray;
    logic [63:0]      a;
    logic [63:0]      hmag;
    logic             hneg;
    logic [127:0]     rad_bits;
    logic [65:0]      rem;
    logic [63:0]      root;
  } sqrt_stage_t;

  // One lane of the root divider.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [63:0]      rem;
    logic [30:0]      q;
    logic             ovf;
    logic             cand;
  } rdiv_lane_t;

  typedef struct packed {
    logic             miss;
    rsi_ray_t         ray;
    logic [63:0]      den;
    rdiv_lane_t [1:0] ln;
  } rdiv_stage_t;

  // One lane of the normal divider.
  typedef struct packed {
    logic [63:0]      num;
    logic [30:0]      rem;
    logic [31:0]      q;
    logic             ovf;
    logic             neg;
  } ndiv_lane_t;

  typedef struct packed {
    logic             miss;
    logic             kind;
    logic [30:0]      t;
    logic [2:0][31:0] pt;
    ndiv_lane_t [2:0] ln;
  } ndiv_stage_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    if ($signed(v) > 64'sh7FFF_FFFF) return POS_MAX;
    if ($signed(v) < -64'sh8000_0000) return NEG_MIN;
    return v[31:0];
  endfunction

  function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s);
    sqrt_stage_t r;
    logic [67:0] rem4;
    logic [67:0] trial;
    logic        ge;
    r     = s;
    rem4  = {s.rem, s.rad_bits[127:126]};
    trial = {2'b00, s.root, 2'b01};
    ge    = rem4 >= trial;
    r.rem      = ge ? 66'(rem4 - trial) : rem4[65:0];
    r.root     = {s.root[62:0], ge};
    r.rad_bits = {s.rad_bits[125:0], 2'b00};
    return r;
  endfunction

  function automatic rdiv_lane_t rdiv_step(input rdiv_lane_t l, input logic [63:0] den);
    rdiv_lane_t r;
    logic [64:0] rem_sh;
    logic        ge;
    r      = l;
    rem_sh = {l.rem, l.num[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den};
    r.rem  = ge ? 64'(rem_sh - {1'b0, den}) : rem_sh[63:0];
    r.num  = {l.num[NUM_W-2:0], 1'b0};
    r.q    = {l.q[29:0], ge};
    r.ovf  = l.ovf | l.q[30];
    return r;
  endfunction

  function automatic ndiv_lane_t ndiv_step(input ndiv_lane_t l, input logic [30:0] den);
    ndiv_lane_t r;
    logic [31:0] rem_sh;
    logic        ge;
    r      = l;
    rem_sh = {l.rem, l.num[63]};
    ge     = rem_sh >= {1'b0, den};
    r.rem  = ge ? 31'(rem_sh - {1'b0, den}) : rem_sh[30:0];
    r.num  = {l.num[62:0], 1'b0};
    r.q    = {l.q[30:0], ge};
    r.ovf  = l.ovf | l.q[31];
    return r;
  endfunction

  // Configuration registers.
  logic [2:0][31:0] center;
  logic [30:0]      radius;
  logic             shadows_enabled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center          <= '0;
      radius          <= RADIUS_RESET;
      shadows_enabled <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X: center[0] <= cfg_data;
        REG_CENTER_Y: center[1] <= cfg_data;
        REG_CENTER_Z: center[2] <= cfg_data;
        REG_RADIUS:   radius <= cfg_data[30:0];
        REG_SHADOWS:  shadows_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Global pipeline advance: everything moves unless the result is held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: offset from center, saturated.
  logic     s1_vld, s1_miss;
  rsi_ray_t s1_ray;
  rsi_ray_t in_ray;

  always_comb begin
    logic [2:0][31:0] o_in;
    logic [2:0][31:0] d_in;
    logic [32:0]      diff;
    o_in = {origin_z, origin_y, origin_x};
    d_in = {dir_z, dir_y, dir_x};
    in_ray.kind = kind;
    in_ray.org  = o_in;
    in_ray.dir  = d_in;
    for (int i = 0; i < 3; i++) begin
      diff = {o_in[i][31], o_in[i]} - {center[i][31], center[i]};
      if (diff[32] != diff[31]) in_ray.off[i] = diff[32] ? NEG_MIN : POS_MAX;
      else in_ray.off[i] = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ray  <= in_ray;
      s1_miss <= kind && !shadows_enabled;
    end
  end

  // Stage 2: component products.
  logic             s2_vld, s2_miss;
  rsi_ray_t         s2_ray;
  logic [2:0][63:0] s2_dd, s2_oo, s2_od;
  logic [2:0]       s2_sx;
  logic [61:0]      s2_r2;

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (adv) s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ray  <= s1_ray;
      s2_miss <= s1_miss;
      s2_r2   <= 62'(radius) * 62'(radius);
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= 64'(mag32(s1_ray.dir[i])) * 64'(mag32(s1_ray.dir[i]));
        s2_oo[i] <= 64'(mag32(s1_ray.off[i])) * 64'(mag32(s1_ray.off[i]));
        s2_od[i] <= 64'(mag32(s1_ray.off[i])) * 64'(mag32(s1_ray.dir[i]));
        s2_sx[i] <= s1_ray.off[i][31] != s1_ray.dir[i][31];
      end
    end
  end

  // Stage 3: dot product sums.
  logic        s3_vld, s3_miss;
  rsi_ray_t    s3_ray;
  logic [63:0] s3_a, s3_s, s3_hp, s3_hn;
  logic [61:0] s3_r2;

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (adv) s3_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ray  <= s2_ray;
      s3_miss <= s2_miss;
      s3_r2   <= s2_r2;
      s3_a    <= s2_dd[0] + s2_dd[1] + s2_dd[2];
      s3_s    <= s2_oo[0] + s2_oo[1] + s2_oo[2];
      s3_hp   <= (s2_sx[0] ? 64'd0 : s2_od[0]) + (s2_sx[1] ? 64'd0 : s2_od[1])
               + (s2_sx[2] ? 64'd0 : s2_od[2]);
      s3_hn   <= (s2_sx[0] ? s2_od[0] : 64'd0) + (s2_sx[1] ? s2_od[1] : 64'd0)
               + (s2_sx[2] ? s2_od[2] : 64'd0);
    end
  end

  // Stage 4: signed magnitudes of H and C.
  logic        s4_vld, s4_miss, s4_hneg, s4_cneg;
  rsi_ray_t    s4_ray;
  logic [63:0] s4_a, s4_hmag, s4_cmag;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (adv) s4_vld <= s3_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ray  <= s3_ray;
      s4_miss <= s3_miss || (s3_a == 64'd0);
      s4_a    <= s3_a;
      s4_hneg <= s3_hn > s3_hp;
      s4_hmag <= (s3_hn > s3_hp) ? (s3_hn - s3_hp) : (s3_hp - s3_hn);
      s4_cneg <= s3_s < {2'b00, s3_r2};
      s4_cmag <= (s3_s < {2'b00, s3_r2}) ? ({2'b00, s3_r2} - s3_s) : (s3_s - {2'b00, s3_r2});
    end
  end

  // Stage 5: 32x32 partial products of H*H and A*C.
  logic        s5_vld, s5_miss, s5_hneg, s5_cneg;
  rsi_ray_t    s5_ray;
  logic [63:0] s5_a, s5_hmag;
  logic [63:0] s5_h00, s5_h01, s5_h11, s5_a00, s5_a01, s5_a10, s5_a11;

  always_ff @(posedge clk) begin
    if (rst) s5_vld <= 1'b0;
    else if (adv) s5_vld <= s4_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ray  <= s4_ray;
      s5_miss <= s4_miss;
      s5_a    <= s4_a;
      s5_hmag <= s4_hmag;
      s5_hneg <= s4_hneg;
      s5_cneg <= s4_cneg;
      s5_h00  <= 64'(s4_hmag[31:0]) * 64'(s4_hmag[31:0]);
      s5_h01  <= 64'(s4_hmag[31:0]) * 64'(s4_hmag[63:32]);
      s5_h11  <= 64'(s4_hmag[63:32]) * 64'(s4_hmag[63:32]);
      s5_a00  <= 64'(s4_a[31:0]) * 64'(s4_cmag[31:0]);
      s5_a01  <= 64'(s4_a[31:0]) * 64'(s4_cmag[63:32]);
      s5_a10  <= 64'(s4_a[63:32]) * 64'(s4_cmag[31:0]);
      s5_a11  <= 64'(s4_a[63:32]) * 64'(s4_cmag[63:32]);
    end
  end

  // Stage 6: assemble the 128-bit products.
  logic         s6_vld, s6_miss, s6_hneg, s6_cneg;
  rsi_ray_t     s6_ray;
  logic [63:0]  s6_a, s6_hmag;
  logic [127:0] s6_h2, s6_ac;

  always_ff @(posedge clk) begin
    if (rst) s6_vld <= 1'b0;
    else if (adv) s6_vld <= s5_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ray  <= s5_ray;
      s6_miss <= s5_miss;
      s6_a    <= s5_a;
      s6_hmag <= s5_hmag;
      s6_hneg <= s5_hneg;
      s6_cneg <= s5_cneg;
      s6_h2   <= {s5_h11, s5_h00} + ({64'd0, s5_h01} << 33);
      s6_ac   <= {s5_a11, s5_a00} + ({64'd0, s5_a01} << 32) + ({64'd0, s5_a10} << 32);
    end
  end

  // Stage 7 (square root entry): discriminant.
  logic        sq_vld [0:SQ_N];
  sqrt_stage_t sq     [0:SQ_N];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (adv) sq_vld[0] <= s6_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].miss     <= s6_miss || (!s6_cneg && (s6_h2 < s6_ac));
      sq[0].ray      <= s6_ray;
      sq[0].a        <= s6_a;
      sq[0].hmag     <= s6_hmag;
      sq[0].hneg     <= s6_hneg;
      sq[0].rad_bits <= s6_cneg ? (s6_h2 + s6_ac) : (s6_h2 - s6_ac);
      sq[0].rem      <= '0;
      sq[0].root     <= '0;
    end
  end

  // Square root: one result bit per stage.
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) sq_vld[j+1] <= 1'b0;
      else if (adv) sq_vld[j+1] <= sq_vld[j];
    end

    always_ff @(posedge clk) begin
      if (adv) sq[j+1] <= sqrt_step(sq[j]);
    end
  end

  // Root numerators for the nearer and farther root.
  logic        dv_vld [0:NUM_W];
  rdiv_stage_t dv     [0:NUM_W];
  rdiv_stage_t sel_next;

  always_comb begin
    logic [63:0] e;
    logic [63:0] hm;
    logic [64:0] num1, num2;
    e  = sq[SQ_N].root;
    hm = sq[SQ_N].hmag;
    num1 = {1'b0, hm - e};
    num2 = sq[SQ_N].hneg ? ({1'b0, hm} + {1'b0, e}) : {1'b0, e - hm};
    sel_next.miss       = sq[SQ_N].miss;
    sel_next.ray        = sq[SQ_N].ray;
    sel_next.den        = sq[SQ_N].a;
    sel_next.ln[0].num  = {num1, {FRAC_BITS{1'b0}}};
    sel_next.ln[0].rem  = '0;
    sel_next.ln[0].q    = '0;
    sel_next.ln[0].ovf  = 1'b0;
    sel_next.ln[0].cand = sq[SQ_N].hneg && (hm > e);
    sel_next.ln[1].num  = {num2, {FRAC_BITS{1'b0}}};
    sel_next.ln[1].rem  = '0;
    sel_next.ln[1].q    = '0;
    sel_next.ln[1].ovf  = 1'b0;
    sel_next.ln[1].cand = sq[SQ_N].hneg || (e > hm);
  end

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (adv) dv_vld[0] <= sq_vld[SQ_N];
  end

  always_ff @(posedge clk) begin
    if (adv) dv[0] <= sel_next;
  end

  // Root division: one quotient bit per stage for both candidates.
  for (genvar j = 0; j < NUM_W; j++) begin : g_rdiv
    always_ff @(posedge clk) begin
      if (rst) dv_vld[j+1] <= 1'b0;
      else if (adv) dv_vld[j+1] <= dv_vld[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j+1].miss  <= dv[j].miss;
        dv[j+1].ray   <= dv[j].ray;
        dv[j+1].den   <= dv[j].den;
        dv[j+1].ln[0] <= rdiv_step(dv[j].ln[0], dv[j].den);
        dv[j+1].ln[1] <= rdiv_step(dv[j].ln[1], dv[j].den);
      end
    end
  end

  // Root choice: nearer root if beyond epsilon, else the farther one.
  logic        rt_vld, rt_miss;
  rsi_ray_t    rt_ray;
  logic [30:0] rt_t;
  logic        ok1, ok2;

  assign ok1 = dv[NUM_W].ln[0].cand && (dv[NUM_W].ln[0].ovf || (dv[NUM_W].ln[0].q > EPS_Q));
  assign ok2 = dv[NUM_W].ln[1].cand && (dv[NUM_W].ln[1].ovf || (dv[NUM_W].ln[1].q > EPS_Q));

  always_ff @(posedge clk) begin
    if (rst) rt_vld <= 1'b0;
    else if (adv) rt_vld <= dv_vld[NUM_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_ray  <= dv[NUM_W].ray;
      rt_miss <= dv[NUM_W].miss || !(ok1 || ok2);
      if (ok1) rt_t <= dv[NUM_W].ln[0].ovf ? T_MAX : dv[NUM_W].ln[0].q;
      else rt_t <= dv[NUM_W].ln[1].ovf ? T_MAX : dv[NUM_W].ln[1].q;
    end
  end

  // Stage: t times direction magnitude.
  logic             ml_vld, ml_miss;
  rsi_ray_t         ml_ray;
  logic [30:0]      ml_t;
  logic [2:0][62:0] ml_pm;

  always_ff @(posedge clk) begin
    if (rst) ml_vld <= 1'b0;
    else if (adv) ml_vld <= rt_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ml_ray  <= rt_ray;
      ml_miss <= rt_miss;
      ml_t    <= rt_t;
      for (int i = 0; i < 3; i++) begin
        ml_pm[i] <= 63'(rt_t) * 63'(mag32(rt_ray.dir[i]));
      end
    end
  end

  // Stage: normal numerator and hit point.
  logic        nd_vld [0:ND_N];
  ndiv_stage_t nd     [0:ND_N];
  ndiv_stage_t nv_next;

  always_comb begin
    logic [63:0] offs;
    logic [63:0] prod;
    logic [63:0] v;
    logic [63:0] step;
    logic [63:0] sum;
    nv_next.miss = ml_miss;
    nv_next.kind = ml_ray.kind;
    nv_next.t    = ml_t;
    for (int i = 0; i < 3; i++) begin
      offs = {{32{ml_ray.off[i][31]}}, ml_ray.off[i]} << FRAC_BITS;
      prod = ml_ray.dir[i][31] ? (64'd0 - {1'b0, ml_pm[i]}) : {1'b0, ml_pm[i]};
      v    = offs + prod;
      step = {1'b0, ml_pm[i]} >> FRAC_BITS;
      sum  = {{32{ml_ray.org[i][31]}}, ml_ray.org[i]}
           + (ml_ray.dir[i][31] ? (64'd0 - step) : step);
      nv_next.pt[i]     = sat32(sum);
      nv_next.ln[i].num = v[63] ? (64'd0 - v) : v;
      nv_next.ln[i].rem = '0;
      nv_next.ln[i].q   = '0;
      nv_next.ln[i].ovf = 1'b0;
      nv_next.ln[i].neg = v[63];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) nd_vld[0] <= 1'b0;
    else if (adv) nd_vld[0] <= ml_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) nd[0] <= nv_next;
  end

  // Normal division by the radius: one quotient bit per stage per axis.
  for (genvar j = 0; j < ND_N; j++) begin : g_ndiv
    always_ff @(posedge clk) begin
      if (rst) nd_vld[j+1] <= 1'b0;
      else if (adv) nd_vld[j+1] <= nd_vld[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        nd[j+1].miss <= nd[j].miss;
        nd[j+1].kind <= nd[j].kind;
        nd[j+1].t    <= nd[j].t;
        nd[j+1].pt   <= nd[j].pt;
        for (int i = 0; i < 3; i++) begin
          nd[j+1].ln[i] <= ndiv_step(nd[j].ln[i], radius);
        end
      end
    end
  end

  // Output register: saturation of the normal and masking of misses and of shadow-ray normal and point.
  logic [2:0][31:0] nrm;

  always_comb begin
    ndiv_lane_t l;
    for (int i = 0; i < 3; i++) begin
      l = nd[ND_N].ln[i];
      if (radius == 31'd0) nrm[i] = '0;
      else if (!l.neg) nrm[i] = (l.ovf || l.q[31]) ? POS_MAX : l.q;
      else if (l.ovf || (l.q[31] && (l.q[30:0] != 31'd0))) nrm[i] = NEG_MIN;
      else nrm[i] = 32'd0 - l.q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= nd_vld[ND_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_found <= !nd[ND_N].miss;
      distance  <= nd[ND_N].miss ? 31'd0 : nd[ND_N].t;
      if (nd[ND_N].miss || nd[ND_N].kind) begin
        normal_x <= '0;
        normal_y <= '0;
        normal_z <= '0;
        point_x  <= '0;
        point_y  <= '0;
        point_z  <= '0;
      end else begin
        normal_x <= nrm[0];
        normal_y <= nrm[1];
        normal_z <= nrm[2];
        point_x  <= nd[ND_N].pt[0];
        point_y  <= nd[ND_N].pt[1];
        point_z  <= nd[ND_N].pt[2];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rsi_checker.sv =====
// -----------------------------------------------------------------------------
// Ray-sphere intersection checker
// Port-level properties of the intersection unit, bound to its top level.
// -----------------------------------------------------------------------------
`default_nettype none

module rsi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        hit_found,
  input wire logic [30:0] distance,
  input wire logic [31:0] normal_x,
  input wire logic [31:0] normal_y,
  input wire logic [31:0] normal_z,
  input wire logic [31:0] point_x,
  input wire logic [31:0] point_y,
  input wire logic [31:0] point_z
);

  // A miss carries an all-zero payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_found |-> distance == 31'd0 && normal_x == 32'd0 &&
      normal_y == 32'd0 && normal_z == 32'd0 && point_x == 32'd0 &&
      point_y == 32'd0 && point_z == 32'd0)
    else $error("miss transaction with nonzero payload");

  // A hit always lies beyond epsilon, so its distance is never zero.
  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_found |-> distance != 31'd0)
    else $error("hit transaction with zero distance");

  // The input is only held back by a held result.
  a_stall_src: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A held result stays valid with its hit flag and distance unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit_found) && $stable(distance))
    else $error("held result changed");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (.*);

`default_nettype wire

// ===== bench/rsi_checker.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Ray-sphere intersection scoreboard
// Watches the ray, result and configuration channels, predicts each result
// from its own copy of the sphere registers and compares it field by field.
// -----------------------------------------------------------------------------
`default_nettype none

module rsi_scoreboard
  import rsi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic                 kind,
  input  wire logic [31:0]          origin_x,
  input  wire logic [31:0]          origin_y,
  input  wire logic [31:0]          origin_z,
  input  wire logic [31:0]          dir_x,
  input  wire logic [31:0]          dir_y,
  input  wire logic [31:0]          dir_z,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic                 hit_found,
  input  wire logic [30:0]          distance,
  input  wire logic [31:0]          normal_x,
  input  wire logic [31:0]          normal_y,
  input  wire logic [31:0]          normal_z,
  input  wire logic [31:0]          point_x,
  input  wire logic [31:0]          point_y,
  input  wire logic [31:0]          point_z,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output int                        fail_count,
  output int                        pending
);

  localparam int FB = FRAC_BITS_DEF;
  // Epsilon, 0.001 in fixed point; a hit distance must lie beyond it.
  localparam logic [127:0] EPS_T = ((128'd1 << FB) + 128'd500) / 128'd1000;

  typedef struct packed {
    logic        hit;
    logic [30:0] t_dist;
    logic [31:0] nx, ny, nz, px, py, pz;
  } hit_rec_t;

  // Local copy of the sphere registers.
  longint      sph_center [3];
  logic [30:0] sph_radius;
  logic        sph_shadows;

  hit_rec_t expected_hits[$];

  function automatic longint sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // Divides a root numerator by a and accepts it if it lies beyond epsilon.
  function automatic logic root_beyond_eps(logic [127:0] num, logic [63:0] a,
                                           output logic [63:0] t);
    logic [127:0] q;
    q = (num << FB) / {64'd0, a};
    t = '0;
    if (q <= EPS_T) return 1'b0;
    t = (q > 128'h7FFF_FFFF) ? 64'h7FFF_FFFF : q[63:0];
    return 1'b1;
  endfunction

  function automatic hit_rec_t predict_hit(logic shadow, logic [2:0][31:0] org,
                                           logic [2:0][31:0] dir);
    hit_rec_t     r;
    longint       o [3];
    longint       d [3];
    longint       off [3];
    logic [63:0]  a, s, hp, hn, hmag, cmag, r2, md, mo, t, pm;
    logic [127:0] h2, ac, dd, e, cand;
    logic         hneg, cneg, found;
    longint       step, prod, v, n;
    logic [31:0]  nrm [3];
    logic [31:0]  pnt [3];
    r = '0;
    a = 0; s = 0; hp = 0; hn = 0; t = 0;
    for (int i = 0; i < 3; i++) begin
      o[i]   = longint'($signed(org[i]));
      d[i]   = longint'($signed(dir[i]));
      off[i] = sat32(o[i] - sph_center[i]);
    end
    if (shadow && !sph_shadows) return r;
    // Dot products on magnitudes, with the sign of the offset term split out.
    for (int i = 0; i < 3; i++) begin
      md = magnitude(d[i]);
      mo = magnitude(off[i]);
      a += md * md;
      s += mo * mo;
      if ((off[i] < 0) != (d[i] < 0)) hn += mo * md;
      else hp += mo * md;
    end
    if (a == 0) return r;
    hneg = hn > hp;
    hmag = hneg ? hn - hp : hp - hn;
    r2   = {33'd0, sph_radius} * {33'd0, sph_radius};
    cneg = s < r2;
    cmag = cneg ? r2 - s : s - r2;
    h2   = {64'd0, hmag} * {64'd0, hmag};
    ac   = {64'd0, a} * {64'd0, cmag};
    if (cneg) begin
      dd = h2 + ac;
    end else begin
      if (h2 < ac) return r;
      dd = h2 - ac;
    end
    // Floor square root of the discriminant.
    e = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = e | (128'd1 << b);
      if (cand * cand <= dd) e = cand;
    end
    // Nearer root first, then the farther one.
    found = 1'b0;
    if (hneg && {64'd0, hmag} > e) found = root_beyond_eps({64'd0, hmag} - e, a, t);
    if (!found) begin
      if (hneg) found = root_beyond_eps({64'd0, hmag} + e, a, t);
      else if (e > {64'd0, hmag}) found = root_beyond_eps(e - {64'd0, hmag}, a, t);
    end
    if (!found) return r;
    r.hit    = 1'b1;
    r.t_dist = t[30:0];
    if (shadow) return r;
    // Normal and hit point from the saturated distance.
    for (int i = 0; i < 3; i++) begin
      pm   = t * magnitude(d[i]);
      step = longint'(pm >> FB);
      prod = longint'(pm);
      if (d[i] < 0) begin
        step = -step;
        prod = -prod;
      end
      v = off[i] * (64'sd1 <<< FB) + prod;
      n = 0;
      if (sph_radius != 0) n = sat32(v / longint'({33'd0, sph_radius}));
      nrm[i] = n[31:0];
      pnt[i] = 32'(sat32(o[i] + step));
    end
    r.nx = nrm[0]; r.ny = nrm[1]; r.nz = nrm[2];
    r.px = pnt[0]; r.py = pnt[1]; r.pz = pnt[2];
    return r;
  endfunction

  // Track configuration writes, queue predictions and check each result.
  always @(posedge clk) begin
    hit_rec_t    exp_r;
    hit_rec_t    act_r;
    logic [31:0] ev [8];
    logic [31:0] av [8];
    string       names [8];
    int          errs;
    errs = 0;
    if (rst) begin
      sph_center[0] <= 0;
      sph_center[1] <= 0;
      sph_center[2] <= 0;
      sph_radius    <= RADIUS_RESET;
      sph_shadows   <= 1'b1;
      expected_hits.delete();
      pending       <= 0;
      fail_count    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X: sph_center[0] <= longint'($signed(cfg_data));
          REG_CENTER_Y: sph_center[1] <= longint'($signed(cfg_data));
          REG_CENTER_Z: sph_center[2] <= longint'($signed(cfg_data));
          REG_RADIUS:   sph_radius    <= cfg_data[30:0];
          REG_SHADOWS:  sph_shadows   <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_hits.push_back(predict_hit(kind, {origin_z, origin_y, origin_x},
                                            {dir_z, dir_y, dir_x}));
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: result transaction with no ray outstanding", $time);
          errs = errs + 1;
        end else begin
          exp_r = expected_hits.pop_front();
          act_r = '{hit_found, distance, normal_x, normal_y, normal_z,
                    point_x, point_y, point_z};
          ev = '{32'(exp_r.hit), 32'(exp_r.t_dist), exp_r.nx, exp_r.ny, exp_r.nz,
                 exp_r.px, exp_r.py, exp_r.pz};
          av = '{32'(act_r.hit), 32'(act_r.t_dist), act_r.nx, act_r.ny, act_r.nz,
                 act_r.px, act_r.py, act_r.pz};
          names = '{"hit_found", "distance", "normal_x", "normal_y", "normal_z",
                    "point_x", "point_y", "point_z"};
          for (int i = 0; i < 8; i++) begin
            if (ev[i] !== av[i]) begin
              $display("%0t: %s mismatch, expected %h, actual %h",
                       $time, names[i], ev[i], av[i]);
              errs = errs + 1;
            end
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= expected_hits.size();
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Ray-sphere intersection testbench
// Streams directed and random rays through the unit under several sphere
// settings and stall patterns; the scoreboard predicts and compares each result.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rsi_pkg::*;

  localparam logic KIND_FULL   = 1'b0;
  localparam logic KIND_SHADOW = 1'b1;
  localparam int   ONE         = 65536;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   DRAIN_WAIT  = 300;
  localparam int   HOLD_AT     = 300;
  localparam int   HOLD_LEN    = 600;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = 1'b0;
  logic [31:0]          origin_x = '0, origin_y = '0, origin_z = '0;
  logic [31:0]          dir_x = '0, dir_y = '0, dir_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 hit_found;
  logic [30:0]          distance;
  logic [31:0]          normal_x, normal_y, normal_z;
  logic [31:0]          point_x, point_y, point_z;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CENTER_X;
  logic [31:0]          cfg_data = '0;
  int                   fail_count;
  int                   pending;

  int     send_idle_pct = 35;
  int     recv_idle_pct = 50;
  int     cycles = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;
  int     rays_sent = 0;
  longint cur_center [3] = '{0, 0, 0};
  longint cur_radius = ONE;

  ray_sphere_intersect_unit uut (.*);
  rsi_scoreboard chk (.*);

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stalls at random, with one long hold during a random
  // phase so the pipeline backs up while rays keep coming.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (!hold_done && rays_sent >= HOLD_AT) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic int rand_span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return int'(v);
  endfunction

  // Offers one ray transaction and waits until it is taken.
  task automatic send_ray(logic k, int ox, int oy, int oz, int dx, int dy, int dz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x    <= dx; dir_y    <= dy; dir_z    <= dz;
    do @(posedge clk); while (in_stall);
    rays_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sphere(int cx, int cy, int cz, int r, logic shadows);
    wait_idle();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
    write_reg(REG_SHADOWS, {31'd0, shadows});
    cur_center = '{cx, cy, cz};
    cur_radius = longint'(r) & 64'h7FFF_FFFF;
  endtask

  // Mostly rays aimed near the sphere, the rest raw noise over every bit.
  task automatic random_rays(int count);
    int     scale;
    int     jit;
    int     off [3];
    int     org [3];
    int     dir [3];
    longint lim;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) begin
        lim   = 4 * cur_radius + ONE;
        scale = (lim > (1 << 29)) ? (1 << 29) : int'(lim);
        jit   = (cur_radius / 2 > (1 << 28)) ? (1 << 28) : int'(cur_radius / 2) + 1;
        for (int i = 0; i < 3; i++) begin
          off[i] = rand_span(scale);
          org[i] = clamp32(cur_center[i] + off[i]);
          dir[i] = ($urandom_range(9) == 0) ? off[i] : -off[i] + rand_span(jit);
          dir[i] = dir[i] >>> $urandom_range(8);
        end
        send_ray(logic'($urandom_range(1)), org[0], org[1], org[2],
                 dir[0], dir[1], dir[2]);
      end else begin
        send_ray(logic'($urandom_range(1)), $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rays against the unit sphere at the origin.
    send_ray(KIND_FULL,   0, 0, -5 * ONE, 0, 0, ONE);
    send_ray(KIND_SHADOW, 0, 0, -5 * ONE, 0, 0, ONE);
    send_ray(KIND_FULL,   0, 0, 0, ONE, 0, 0);
    send_ray(KIND_FULL,   0, 0, 5 * ONE, 0, 0, ONE);
    send_ray(KIND_FULL,   ONE, 2, 3, 0, 0, 0);
    send_ray(KIND_FULL,   3 * ONE, 0, -5 * ONE, 0, 0, ONE);
    send_ray(KIND_FULL,   ONE, 0, -5 * ONE, 0, 0, ONE);
    send_ray(KIND_FULL,   0, 0, -30000 * ONE, 0, 0, 1);
    send_ray(KIND_FULL,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(KIND_FULL,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(KIND_SHADOW, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_ray(KIND_FULL,   -2 * ONE, 0, 0, 1, 0, 0);
    send_ray(KIND_FULL,   0, -ONE / 2, 0, 0, 32'h7FFF_FFFF, 0);

    // Shadows disabled, then a zero radius.
    set_sphere(0, 0, 0, ONE, 1'b0);
    send_ray(KIND_SHADOW, 0, 0, -5 * ONE, 0, 0, ONE);
    send_ray(KIND_FULL,   0, 0, -5 * ONE, 0, 0, ONE);
    set_sphere(0, 0, 0, 0, 1'b1);
    send_ray(KIND_FULL,   0, 0, -5 * ONE, 0, 0, ONE);
    send_ray(KIND_FULL,   0, 0, 0, 0, ONE, 0);

    // Random phases over several sphere settings and stall patterns.
    set_sphere(3 * ONE, -2 * ONE, 5 * ONE, 2 * ONE, 1'b1);
    random_rays(130);
    set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    random_rays(130);
    send_idle_pct = 50;
    recv_idle_pct = 35;
    set_sphere(0, 0, 0, 0, 1'b1);
    random_rays(130);
    set_sphere(32'h8000_0000, 0, 32'h7FFF_FFFF, 1, 1'b0);
    random_rays(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sphere(rand_span(100 * ONE), rand_span(100 * ONE), rand_span(100 * ONE),
               $urandom_range(10 * ONE), logic'($urandom_range(1)));
    random_rays(130);
    set_sphere(-3 * ONE / 2, 29 * ONE / 4, 0, ONE / 2, 1'b1);
    random_rays(130);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d rays over nine sphere settings, including extreme centers,",
             rays_sent);
    $display("zero and maximum radius, disabled shadows and three stall patterns.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
